[src/safp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// safp_pkg
// Shared types and constants for the servo angle frame parser.
// ----------------------------------------------------------------------------
package safp_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned ANGLE_W = 10;
  localparam int unsigned MISS_W  = 9;
  localparam logic [MISS_W-1:0] MISS_CAP = 9'd256;

  // angle = value * ANGLE_SPAN / FULL_SCALE, reduced to value * 9 / 880
  localparam int unsigned ANGLE_SPAN  = 180;
  localparam int unsigned FULL_SCALE  = 17600;
  localparam int unsigned SCALE_GCD   = 20;
  localparam int unsigned SPAN_NUM    = ANGLE_SPAN / SCALE_GCD;
  localparam int unsigned SPAN_DEN    = FULL_SCALE / SCALE_GCD;
  localparam int unsigned NUM_W       = 20;
  localparam int unsigned SCALE_SHIFT = 30;
  localparam int unsigned MULT_W      = 21;
  localparam int unsigned PROD_W      = NUM_W + MULT_W;
  localparam longint unsigned SCALE_MULT =
    ((64'd1 << SCALE_SHIFT) + SPAN_DEN - 1) / SPAN_DEN;

  localparam logic [BYTE_W-1:0] RST_START_MARKER    = 8'd0;
  localparam logic [BYTE_W-1:0] RST_TAG_SERVO0      = 8'd1;
  localparam logic [BYTE_W-1:0] RST_TAG_SERVO1      = 8'd2;
  localparam logic [BYTE_W-1:0] RST_TAG_SERVO2      = 8'd3;
  localparam logic [BYTE_W-1:0] RST_END_MARKER      = 8'd255;
  localparam logic [BYTE_W-1:0] RST_SYNC_FAIL_LIMIT = 8'd100;

  localparam logic [1:0] LAST_SLOT = 2'd2;

  typedef enum logic [1:0] {
    KIND_ANGLE     = 2'd0,
    KIND_FRAME_OK  = 2'd1,
    KIND_BAD_END   = 2'd2,
    KIND_SYNC_LOST = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_TAG  = 3'd1,
    PH_HIGH = 3'd2,
    PH_LOW  = 3'd3,
    PH_END  = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    REG_START_MARKER    = 3'd0,
    REG_TAG_SERVO0      = 3'd1,
    REG_TAG_SERVO1      = 3'd2,
    REG_TAG_SERVO2      = 3'd3,
    REG_END_MARKER      = 3'd4,
    REG_SYNC_FAIL_LIMIT = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [BYTE_W-1:0] start_marker;
    logic [BYTE_W-1:0] tag_servo0;
    logic [BYTE_W-1:0] tag_servo1;
    logic [BYTE_W-1:0] tag_servo2;
    logic [BYTE_W-1:0] end_marker;
    logic [BYTE_W-1:0] sync_fail_limit;
  } cfg_t;

  typedef struct packed {
    kind_t              kind;
    logic [1:0]         servo_index;
    logic [VALUE_W-1:0] value;
  } mid_word_t;

endpackage
`default_nettype wire

[src/safp_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// safp_front
// Byte parser: hunts for the start marker, walks the tag slots and emits
// one word per event into the middle queue.
// ----------------------------------------------------------------------------
module safp_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  input  wire logic [safp_pkg::BYTE_W-1:0] rx_byte,
  input  wire safp_pkg::cfg_t              cfg,
  input  wire logic                        q_full,
  output logic                             q_push,
  output safp_pkg::mid_word_t              q_word
);

  safp_pkg::phase_t                 phase;
  safp_pkg::phase_t                 phase_next;
  logic [1:0]                       slot;
  logic [1:0]                       slot_next;
  logic [safp_pkg::BYTE_W-1:0]      high_byte;
  logic [safp_pkg::BYTE_W-1:0]      high_byte_next;
  logic [safp_pkg::MISS_W-1:0]      miss_count;
  logic [safp_pkg::MISS_W-1:0]      miss_count_next;

  logic                             accept;
  logic [safp_pkg::BYTE_W-1:0]      slot_tag;
  logic [safp_pkg::MISS_W-1:0]      miss_inc;
  logic                             sync_lost;
  logic                             is_start;

  assign accept   = push & ~q_full;
  assign is_start = (rx_byte == cfg.start_marker);
  assign miss_inc = (miss_count == safp_pkg::MISS_CAP) ? miss_count
                                                       : miss_count + 1'b1;
  assign sync_lost = miss_inc > {1'b0, cfg.sync_fail_limit};

  always_comb begin
    case (slot)
      2'd0:    slot_tag = cfg.tag_servo0;
      2'd1:    slot_tag = cfg.tag_servo1;
      default: slot_tag = cfg.tag_servo2;
    endcase
  end

  // next state
  always_comb begin
    phase_next      = phase;
    slot_next       = slot;
    high_byte_next  = high_byte;
    miss_count_next = miss_count;
    if (accept) begin
      unique case (phase)
        safp_pkg::PH_TAG: begin
          if (rx_byte == slot_tag) begin
            phase_next = safp_pkg::PH_HIGH;
          end else if (slot >= safp_pkg::LAST_SLOT) begin
            phase_next = safp_pkg::PH_END;
          end else begin
            slot_next  = slot + 1'b1;
            phase_next = safp_pkg::PH_TAG;
          end
        end
        safp_pkg::PH_HIGH: begin
          high_byte_next = rx_byte;
          phase_next     = safp_pkg::PH_LOW;
        end
        safp_pkg::PH_LOW: begin
          if (slot >= safp_pkg::LAST_SLOT) begin
            phase_next = safp_pkg::PH_END;
          end else begin
            slot_next  = slot + 1'b1;
            phase_next = safp_pkg::PH_TAG;
          end
        end
        safp_pkg::PH_END: begin
          phase_next = safp_pkg::PH_HUNT;
          slot_next  = 2'd0;
        end
        default: begin
          phase_next = safp_pkg::PH_HUNT;
          if (is_start) begin
            miss_count_next = '0;
            slot_next       = 2'd0;
            phase_next      = safp_pkg::PH_TAG;
          end else begin
            miss_count_next = miss_inc;
          end
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    q_push             = 1'b0;
    q_word.kind        = safp_pkg::KIND_ANGLE;
    q_word.servo_index = 2'd0;
    q_word.value       = '0;
    if (accept) begin
      unique case (phase) inside
        safp_pkg::PH_TAG, safp_pkg::PH_HIGH: begin
          q_push = 1'b0;
        end
        safp_pkg::PH_LOW: begin
          q_push             = 1'b1;
          q_word.servo_index = slot;
          q_word.value       = {high_byte, rx_byte};
        end
        safp_pkg::PH_END: begin
          q_push      = 1'b1;
          q_word.kind = (rx_byte == cfg.end_marker) ? safp_pkg::KIND_FRAME_OK
                                                    : safp_pkg::KIND_BAD_END;
        end
        default: begin
          q_push      = ~is_start & sync_lost;
          q_word.kind = safp_pkg::KIND_SYNC_LOST;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= safp_pkg::PH_HUNT;
      slot       <= 2'd0;
      high_byte  <= '0;
      miss_count <= '0;
    end else begin
      phase      <= phase_next;
      slot       <= slot_next;
      high_byte  <= high_byte_next;
      miss_count <= miss_count_next;
    end
  end

endmodule
`default_nettype wire

[src/safp_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// safp_queue
// Short register queue that decouples the parser from the scaler.
// ----------------------------------------------------------------------------
module safp_queue #(
  parameter int unsigned DEPTH = safp_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                wr_en,
  input  wire safp_pkg::mid_word_t wr_word,
  output logic                     full,
  input  wire logic                rd_en,
  output safp_pkg::mid_word_t      rd_word,
  output logic                     not_empty
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  safp_pkg::mid_word_t entries [DEPTH];
  logic [AW-1:0]       wr_ptr;
  logic [AW-1:0]       rd_ptr;
  logic [CW-1:0]       count;
  logic                do_wr;
  logic                do_rd;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign do_wr     = wr_en & ~full;
  assign do_rd     = rd_en & not_empty;
  assign rd_word   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr & ~do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd & ~do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[src/safp_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// safp_back
// Scaler and output register: value * 9 / 880 by reciprocal multiply,
// then a result word held until popped.
// ----------------------------------------------------------------------------
module safp_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         q_valid,
  input  wire safp_pkg::mid_word_t          q_word,
  output logic                              q_pop,
  output logic                              empty,
  input  wire logic                         pop,
  output logic [1:0]                        kind,
  output logic [1:0]                        servo_index,
  output logic [safp_pkg::ANGLE_W-1:0]      angle
);

  logic                           s1_valid;
  safp_pkg::kind_t                s1_kind;
  logic [1:0]                     s1_index;
  logic [safp_pkg::PROD_W-1:0]    s1_prod;
  logic                           out_valid;
  logic                           out_load;
  logic                           s1_load;
  logic [safp_pkg::NUM_W-1:0]     scaled_num;
  logic [safp_pkg::PROD_W-1:0]    prod;

  assign out_load = s1_valid & (~out_valid | pop);
  assign s1_load  = q_valid & (~s1_valid | out_load);
  assign q_pop    = s1_load;
  assign empty    = ~out_valid;

  assign scaled_num = safp_pkg::NUM_W'(q_word.value) *
                      safp_pkg::NUM_W'(safp_pkg::SPAN_NUM);
  assign prod       = safp_pkg::PROD_W'(scaled_num) *
                      safp_pkg::PROD_W'(safp_pkg::SCALE_MULT);

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_kind  <= q_word.kind;
      s1_index <= q_word.servo_index;
      s1_prod  <= prod;
    end
    if (out_load) begin
      kind        <= s1_kind;
      servo_index <= s1_index;
      angle       <= s1_prod[safp_pkg::SCALE_SHIFT +: safp_pkg::ANGLE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= 1'b1;
      end else if (out_load) begin
        s1_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

[src/servo_angle_frame_parser_top.sv]
// Path: a result word passes through the middle queue, the multiply stage
// and the output register before it reaches the outputs.
// Throughput: one byte per cycle unless full; the scaler takes one word per
// cycle unless held. full rises only when the middle queue is full under
// output back-pressure. Reset: synchronous, active high; the parser returns
// to hunting, the queue empties, configuration registers return to defaults.
`default_nettype none
// ----------------------------------------------------------------------------
// servo_angle_frame_parser_top
// Servo angle frame parser: byte parser, middle queue, scaler, APB registers.
// ----------------------------------------------------------------------------
module servo_angle_frame_parser_top #(
  parameter int unsigned QUEUE_DEPTH = safp_pkg::QUEUE_DEPTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [safp_pkg::BYTE_W-1:0] rx_byte,
  output logic                             empty,
  input  wire logic                        pop,
  output logic [1:0]                       kind,
  output logic [1:0]                       servo_index,
  output logic [safp_pkg::ANGLE_W-1:0]     angle,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [safp_pkg::ADDR_W-1:0] paddr,
  input  wire logic [safp_pkg::DATA_W-1:0] pwdata,
  output logic [safp_pkg::DATA_W-1:0]      prdata,
  output logic                             pready
);

  safp_pkg::cfg_t       cfg;
  safp_pkg::reg_index_t reg_sel;
  logic                 cfg_wr;
  logic                 mid_push;
  safp_pkg::mid_word_t  mid_wr_word;
  logic                 mid_pop;
  safp_pkg::mid_word_t  mid_rd_word;
  logic                 mid_valid;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_sel = safp_pkg::reg_index_t'(paddr[safp_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_marker    <= safp_pkg::RST_START_MARKER;
      cfg.tag_servo0      <= safp_pkg::RST_TAG_SERVO0;
      cfg.tag_servo1      <= safp_pkg::RST_TAG_SERVO1;
      cfg.tag_servo2      <= safp_pkg::RST_TAG_SERVO2;
      cfg.end_marker      <= safp_pkg::RST_END_MARKER;
      cfg.sync_fail_limit <= safp_pkg::RST_SYNC_FAIL_LIMIT;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        safp_pkg::REG_START_MARKER:    cfg.start_marker    <= pwdata[7:0];
        safp_pkg::REG_TAG_SERVO0:      cfg.tag_servo0      <= pwdata[7:0];
        safp_pkg::REG_TAG_SERVO1:      cfg.tag_servo1      <= pwdata[7:0];
        safp_pkg::REG_TAG_SERVO2:      cfg.tag_servo2      <= pwdata[7:0];
        safp_pkg::REG_END_MARKER:      cfg.end_marker      <= pwdata[7:0];
        safp_pkg::REG_SYNC_FAIL_LIMIT: cfg.sync_fail_limit <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      safp_pkg::REG_START_MARKER:    prdata = {24'd0, cfg.start_marker};
      safp_pkg::REG_TAG_SERVO0:      prdata = {24'd0, cfg.tag_servo0};
      safp_pkg::REG_TAG_SERVO1:      prdata = {24'd0, cfg.tag_servo1};
      safp_pkg::REG_TAG_SERVO2:      prdata = {24'd0, cfg.tag_servo2};
      safp_pkg::REG_END_MARKER:      prdata = {24'd0, cfg.end_marker};
      safp_pkg::REG_SYNC_FAIL_LIMIT: prdata = {24'd0, cfg.sync_fail_limit};
      default:                       prdata = '0;
    endcase
  end

  safp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .rx_byte (rx_byte),
    .cfg     (cfg),
    .q_full  (full),
    .q_push  (mid_push),
    .q_word  (mid_wr_word)
  );

  safp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (mid_push),
    .wr_word   (mid_wr_word),
    .full      (full),
    .rd_en     (mid_pop),
    .rd_word   (mid_rd_word),
    .not_empty (mid_valid)
  );

  safp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (mid_valid),
    .q_word      (mid_rd_word),
    .q_pop       (mid_pop),
    .empty       (empty),
    .pop         (pop),
    .kind        (kind),
    .servo_index (servo_index),
    .angle       (angle)
  );

  a_angle_range : assert property (@(posedge clk) disable iff (rst)
    !empty |-> angle <= 10'd670)
    else $error("angle out of range");

  a_status_clean : assert property (@(posedge clk) disable iff (rst)
    (!empty && kind != safp_pkg::KIND_ANGLE) |-> (servo_index == 2'd0 && angle == '0))
    else $error("status word carries servo data");

  a_servo_index : assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == safp_pkg::KIND_ANGLE) |-> servo_index <= safp_pkg::LAST_SLOT)
    else $error("servo index out of range");

  a_no_push_full : assert property (@(posedge clk) disable iff (rst)
    full |-> !mid_push)
    else $error("parser wrote into a full queue");

endmodule
`default_nettype wire

[verif/servo_angle_frame_parser_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// servo_angle_frame_parser_top_tb
// Self-checking bench for the servo angle frame parser. A clocked driver
// feeds bytes from a backlog, a clocked monitor pops result words and checks
// them against a parser model kept in the bench. Register settings change
// between phases while idle; phases vary sender and receiver idling, and one
// phase holds off the receiver long enough to back up the input.
// ----------------------------------------------------------------------------
module servo_angle_frame_parser_top_tb;
  import safp_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam logic [2:0]  REG_SPARE_A   = 3'd6;
  localparam logic [2:0]  REG_SPARE_B   = 3'd7;

  typedef struct packed {
    kind_t              kind;
    logic [1:0]         servo_index;
    logic [ANGLE_W-1:0] angle;
  } report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [BYTE_W-1:0] rx_byte = '0;
  logic empty;
  logic pop = 1'b0;
  logic [1:0] kind;
  logic [1:0] servo_index;
  logic [ANGLE_W-1:0] angle;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  servo_angle_frame_parser_top dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .rx_byte(rx_byte),
    .empty(empty), .pop(pop),
    .kind(kind), .servo_index(servo_index), .angle(angle),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // bench-side parser state
  cfg_t             cfg_model;
  phase_t           phase_q;
  logic [1:0]       slot_q;
  logic [7:0]       high_q;
  logic [MISS_W-1:0] miss_q;

  logic [7:0] byte_backlog[$];
  report_t    parser_reports[$];
  int         bytes_queued = 0;
  int         bytes_taken = 0;
  int         mismatches = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  logic       hold_go = 1'b0;
  logic       stall_rx = 1'b0;
  report_t    want;

  function automatic logic [7:0] slot_tag(input logic [1:0] s);
    if (s == 2'd0) return cfg_model.tag_servo0;
    if (s == 2'd1) return cfg_model.tag_servo1;
    return cfg_model.tag_servo2;
  endfunction

  task automatic advance_slot();
    if (slot_q >= LAST_SLOT) begin
      phase_q = PH_END;
    end else begin
      slot_q  = slot_q + 2'd1;
      phase_q = PH_TAG;
    end
  endtask

  task automatic parse_byte(input logic [7:0] b);
    report_t r;
    int unsigned v;
    case (phase_q)
      PH_TAG: begin
        if (b == slot_tag(slot_q)) phase_q = PH_HIGH;
        else advance_slot();
      end
      PH_HIGH: begin
        high_q  = b;
        phase_q = PH_LOW;
      end
      PH_LOW: begin
        v = 32'({high_q, b});
        r.kind = KIND_ANGLE;
        r.servo_index = slot_q;
        r.angle = ANGLE_W'((v * ANGLE_SPAN) / FULL_SCALE);
        parser_reports.push_back(r);
        advance_slot();
      end
      PH_END: begin
        phase_q = PH_HUNT;
        slot_q  = 2'd0;
        r.kind = (b == cfg_model.end_marker) ? KIND_FRAME_OK : KIND_BAD_END;
        r.servo_index = 2'd0;
        r.angle = '0;
        parser_reports.push_back(r);
      end
      default: begin
        phase_q = PH_HUNT;
        if (b == cfg_model.start_marker) begin
          miss_q  = '0;
          slot_q  = 2'd0;
          phase_q = PH_TAG;
        end else begin
          if (miss_q < MISS_CAP) miss_q = miss_q + 1'b1;
          if (miss_q > {1'b0, cfg_model.sync_fail_limit}) begin
            r.kind = KIND_SYNC_LOST;
            r.servo_index = 2'd0;
            r.angle = '0;
            parser_reports.push_back(r);
          end
        end
      end
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        parse_byte(rx_byte);
        bytes_taken++;
      end
      if (!(push && full)) begin
        if (byte_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          push    <= 1'b1;
          rx_byte <= byte_backlog.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (parser_reports.size() == 0) begin
          $display("%0t: unexpected word kind=%0d servo_index=%0d angle=%0d",
                   $time, kind, servo_index, angle);
          mismatches++;
        end else begin
          want = parser_reports.pop_front();
          if (kind !== want.kind) begin
            $display("%0t: kind expected %0d actual %0d", $time, want.kind, kind);
            mismatches++;
          end
          if (servo_index !== want.servo_index) begin
            $display("%0t: servo_index expected %0d actual %0d",
                     $time, want.servo_index, servo_index);
            mismatches++;
          end
          if (angle !== want.angle) begin
            $display("%0t: angle expected %0d actual %0d", $time, want.angle, angle);
            mismatches++;
          end
        end
      end
      pop <= !stall_rx && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off
  initial begin
    wait (hold_go);
    @(posedge clk);
    stall_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    stall_rx <= 1'b0;
  end

  initial begin
    #5000000;
    $display("servo_angle_frame_parser_top_tb: errors");
    $finish;
  end

  task automatic reg_write(input logic [2:0] idx, input logic [7:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= {24'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_START_MARKER:    cfg_model.start_marker    = val;
      REG_TAG_SERVO0:      cfg_model.tag_servo0      = val;
      REG_TAG_SERVO1:      cfg_model.tag_servo1      = val;
      REG_TAG_SERVO2:      cfg_model.tag_servo2      = val;
      REG_END_MARKER:      cfg_model.end_marker      = val;
      REG_SYNC_FAIL_LIMIT: cfg_model.sync_fail_limit = val;
      default: ;
    endcase
  endtask

  task automatic reg_check(input logic [2:0] idx, input logic [7:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_W'({idx, 2'b00});
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {24'd0, val}) begin
      $display("%0t: register %0d expected %0h actual %0h", $time, idx, val, prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_all_regs();
    reg_check(REG_START_MARKER,    cfg_model.start_marker);
    reg_check(REG_TAG_SERVO0,      cfg_model.tag_servo0);
    reg_check(REG_TAG_SERVO1,      cfg_model.tag_servo1);
    reg_check(REG_TAG_SERVO2,      cfg_model.tag_servo2);
    reg_check(REG_END_MARKER,      cfg_model.end_marker);
    reg_check(REG_SYNC_FAIL_LIMIT, cfg_model.sync_fail_limit);
  endtask

  task automatic set_config(input cfg_t c);
    reg_write(REG_START_MARKER,    c.start_marker);
    reg_write(REG_TAG_SERVO0,      c.tag_servo0);
    reg_write(REG_TAG_SERVO1,      c.tag_servo1);
    reg_write(REG_TAG_SERVO2,      c.tag_servo2);
    reg_write(REG_END_MARKER,      c.end_marker);
    reg_write(REG_SYNC_FAIL_LIMIT, c.sync_fail_limit);
    check_all_regs();
  endtask

  task automatic queue_byte(input logic [7:0] b);
    byte_backlog.push_back(b);
    bytes_queued++;
  endtask

  task automatic gen_stream(input int n);
    int base;
    int r;
    int k;
    int len;
    logic [15:0] v;
    base = bytes_queued;
    while (bytes_queued - base < n) begin
      r = $urandom_range(99);
      if (r < 70) begin
        queue_byte(cfg_model.start_marker);
        for (k = 0; k < 3; k++) begin
          if ($urandom_range(4) != 0) begin
            queue_byte(slot_tag(k[1:0]));
            case ($urandom_range(5))
              0: v = 16'h0000;
              1: v = 16'hFFFF;
              2: v = 16'(FULL_SCALE);
              default: v = 16'($urandom);
            endcase
            queue_byte(v[15:8]);
            queue_byte(v[7:0]);
          end else begin
            queue_byte(8'($urandom));
          end
        end
        queue_byte($urandom_range(6) == 0 ? 8'($urandom) : cfg_model.end_marker);
      end else if (r < 88) begin
        len = $urandom_range(12, 1);
        repeat (len) queue_byte(8'($urandom));
      end else begin
        queue_byte(cfg_model.start_marker);
        len = $urandom_range(4, 1);
        repeat (len) queue_byte(8'($urandom));
      end
    end
  endtask

  task automatic drain();
    while (bytes_taken != bytes_queued || parser_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(input int snd, input int rcv, input int n);
    send_idle_pct  = snd;
    recv_stall_pct = rcv;
    gen_stream(n);
    drain();
  endtask

  function automatic cfg_t random_cfg(input logic [7:0] limit);
    cfg_t c;
    c.start_marker    = 8'($urandom);
    c.tag_servo0      = 8'($urandom);
    c.tag_servo1      = 8'($urandom);
    c.tag_servo2      = 8'($urandom);
    c.end_marker      = 8'($urandom);
    c.sync_fail_limit = limit;
    return c;
  endfunction

  initial begin
    logic [7:0] directed[$];
    logic [7:0] b;
    cfg_model = '{RST_START_MARKER, RST_TAG_SERVO0, RST_TAG_SERVO1, RST_TAG_SERVO2,
                  RST_END_MARKER, RST_SYNC_FAIL_LIMIT};
    phase_q = PH_HUNT;
    slot_q  = 2'd0;
    high_q  = 8'd0;
    miss_q  = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    check_all_regs();

    // full frame with zero, max and full-scale values, then frame ok
    directed = {8'h00, 8'h01, 8'h00, 8'h00, 8'h02, 8'hFF, 8'hFF, 8'h03, 8'h44, 8'hC0,
                8'hFF,
    // markers read as tags inside a frame, bad end
                8'h00, 8'hFF, 8'h00, 8'h03, 8'h00, 8'h62, 8'h00,
    // every slot skipped
                8'h00, 8'h07, 8'h08, 8'h09, 8'h01,
    // a miss, then a start that clears it
                8'h80, 8'h00};
    foreach (directed[i]) queue_byte(directed[i]);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    drain();
    // finish the frame the last start opened
    queue_byte(8'h00);
    queue_byte(8'h00);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    drain();

    set_config(random_cfg(8'($urandom_range(8))));
    run_phase(68, 0, 180);

    set_config('{8'hFF, 8'h00, 8'hFF, 8'h80, 8'h00, 8'h00});
    run_phase(0, 68, 180);

    // largest limit; a long miss run drives the counter into saturation
    set_config('{8'h5A, 8'($urandom), 8'($urandom), 8'($urandom), 8'hA5, 8'hFF});
    send_idle_pct  = 26;
    recv_stall_pct = 26;
    gen_stream(100);
    repeat (300) begin
      b = 8'($urandom);
      if (b == cfg_model.start_marker) b = b ^ 8'h01;
      queue_byte(b);
    end
    gen_stream(100);
    drain();

    set_config(random_cfg(8'd3));
    hold_go = 1'b1;
    run_phase(0, 0, 180);

    set_config('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    reg_write(REG_SPARE_A, 8'($urandom));
    reg_write(REG_SPARE_B, 8'($urandom));
    check_all_regs();
    run_phase(0, 68, 180);

    set_config('{RST_START_MARKER, RST_TAG_SERVO0, RST_TAG_SERVO1, RST_TAG_SERVO2,
                 RST_END_MARKER, 8'd1});
    run_phase(26, 26, 100);

    if (mismatches == 0) begin
      $display("servo_angle_frame_parser_top_tb: clean");
    end else begin
      $display("servo_angle_frame_parser_top_tb: errors");
    end
    $finish;
  end

endmodule
